@@ hdl/spc_pkg.sv @@
// Shared types for the signed permutation checker.
`default_nettype none

package spc_pkg;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_SCAN,
        ST_FLUSH
    } t_state;

    // Verdict codes.
    typedef enum logic [2:0] {
        STAT_OK      = 3'd0,
        STAT_ZERO    = 3'd1,
        STAT_LARGE   = 3'd2,
        STAT_DUP     = 3'd3,
        STAT_MISSING = 3'd4
    } t_status;

    localparam int GENE_W  = 16;
    localparam int COUNT_W = 11;
    localparam logic [COUNT_W-1:0] GENE_COUNT_RESET = 11'd1024;

endpackage

`default_nettype wire

@@ hdl/signed_permutation_checker_core.sv @@
// Signed permutation checker: streams signed genes, tracks seen magnitudes, gives one verdict.
//
// Each word carries one signed gene and a last marker. A gene whose magnitude is zero or
// above the count is handled in the idle state alone. A gene in range needs a read of the
// seen-map memory and, if the gene is new, a write back in the lookup state. On the last
// word the sequencer then sweeps the seen-map one entry per cycle, finding the smallest
// missing number while clearing each entry. The sweep covers the effective count N (the
// smaller of gene_count and MAX_GENES), or the highest gene marked in the list when that
// is larger because gene_count was lowered partway through. The verdict is shown for
// exactly one cycle with o_valid and must be taken then; the receiver cannot stall it.
// After reset the block clears every seen-map entry and holds o_busy high meanwhile;
// gene_count may be written any time the block is idle.
`default_nettype none

module signed_permutation_checker_core #(
    parameter int MAX_GENES = 1024
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_we,
    input  wire logic [spc_pkg::COUNT_W-1:0]           i_cfg_wdata,
    input  wire logic                                  i_start,
    input  wire logic signed [spc_pkg::GENE_W-1:0]     i_gene_value,
    input  wire logic                                  i_is_last,
    output logic                                       o_busy,
    output logic                                       o_valid,
    output logic [2:0]                                 o_status,
    output logic signed [spc_pkg::GENE_W-1:0]          o_bad_value
);

    localparam int AW = (MAX_GENES > 1) ? $clog2(MAX_GENES) : 1;
    localparam int CW = $clog2(MAX_GENES + 1);
    localparam logic [15:0] MAX_N = 16'(MAX_GENES);
    localparam logic [CW-1:0] CLEAR_LAST = CW'(MAX_GENES - 1);

    spc_pkg::t_state  r_state, n_state;
    spc_pkg::t_status r_err, n_err;
    logic [15:0]      r_err_val, n_err_val;

    logic [spc_pkg::COUNT_W-1:0] r_gene_count;
    logic [AW-1:0]    r_addr;
    logic             r_last;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [CW-1:0]    r_hi;
    logic             r_chk_valid;
    logic [AW-1:0]    r_chk_idx;
    logic             r_rd_data;

    logic             r_out_valid;
    logic [2:0]       r_out_status;
    logic [15:0]      r_out_value;

    logic [15:0]      eff_n;
    logic [15:0]      scan_end;
    logic [16:0]      mag;
    logic             in_zero, in_large, in_range, accept;
    logic             scan_issue;

    logic             mem_re, mem_we, mem_wdata;
    logic [AW-1:0]    mem_raddr, mem_waddr;
    logic             mem [MAX_GENES];

    logic             ev;
    spc_pkg::t_status ev_code;
    logic [15:0]      ev_val;

    // Effective count, sweep length and magnitude of the incoming gene.
    always_comb begin
        eff_n = ({5'd0, r_gene_count} > MAX_N) ? MAX_N : {5'd0, r_gene_count};
        scan_end = (16'(r_hi) > eff_n) ? 16'(r_hi) : eff_n;
        mag = i_gene_value[15] ? (17'd0 - {i_gene_value[15], i_gene_value})
                               : {1'b0, i_gene_value};
        in_zero = (mag == 17'd0);
        in_large = !in_zero && (mag > {1'b0, eff_n});
        in_range = !in_zero && !in_large;
        accept = i_start && (r_state == spc_pkg::ST_IDLE);
        scan_issue = (r_state == spc_pkg::ST_SCAN) && (16'(r_cnt) < scan_end);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            spc_pkg::ST_CLEAR: begin
                if (r_cnt == CLEAR_LAST) n_state = spc_pkg::ST_IDLE;
            end
            spc_pkg::ST_IDLE: begin
                if (accept) begin
                    if (in_range) n_state = spc_pkg::ST_LOOKUP;
                    else if (i_is_last) n_state = spc_pkg::ST_SCAN;
                end
            end
            spc_pkg::ST_LOOKUP: begin
                n_state = r_last ? spc_pkg::ST_SCAN : spc_pkg::ST_IDLE;
            end
            spc_pkg::ST_SCAN: begin
                if (!scan_issue) n_state = spc_pkg::ST_FLUSH;
            end
            spc_pkg::ST_FLUSH: begin
                n_state = spc_pkg::ST_IDLE;
            end
            default: n_state = spc_pkg::ST_IDLE;
        endcase
    end

    // Memory controls and counter, driven by the state.
    always_comb begin
        mem_re = 1'b0;
        mem_we = 1'b0;
        mem_wdata = 1'b0;
        mem_raddr = r_cnt[AW-1:0];
        mem_waddr = r_cnt[AW-1:0];
        n_cnt = '0;
        unique case (r_state)
            spc_pkg::ST_CLEAR: begin
                mem_we = 1'b1;
                n_cnt = r_cnt + CW'(1);
            end
            spc_pkg::ST_IDLE: begin
                mem_re = accept && in_range;
                mem_raddr = AW'(mag - 17'd1);
            end
            spc_pkg::ST_LOOKUP: begin
                mem_we = !r_rd_data;
                mem_waddr = r_addr;
                mem_wdata = 1'b1;
            end
            spc_pkg::ST_SCAN: begin
                // Read and clear one entry per cycle.
                mem_re = scan_issue;
                mem_we = scan_issue;
                n_cnt = scan_issue ? (r_cnt + CW'(1)) : r_cnt;
            end
            spc_pkg::ST_FLUSH: begin
                n_cnt = '0;
            end
            default: n_cnt = '0;
        endcase
    end

    // Error events; only the first one of a list is latched.
    always_comb begin
        ev = 1'b0;
        ev_code = spc_pkg::STAT_OK;
        ev_val = 16'd0;
        if (accept && in_zero) begin
            ev = 1'b1;
            ev_code = spc_pkg::STAT_ZERO;
            ev_val = i_gene_value;
        end else if (accept && in_large) begin
            ev = 1'b1;
            ev_code = spc_pkg::STAT_LARGE;
            ev_val = i_gene_value;
        end else if ((r_state == spc_pkg::ST_LOOKUP) && r_rd_data) begin
            ev = 1'b1;
            ev_code = spc_pkg::STAT_DUP;
            ev_val = 16'(r_addr) + 16'd1;
        end else if (r_chk_valid && !r_rd_data) begin
            ev = 1'b1;
            ev_code = spc_pkg::STAT_MISSING;
            ev_val = 16'(r_chk_idx) + 16'd1;
        end
        n_err = r_err;
        n_err_val = r_err_val;
        if (ev && (r_err == spc_pkg::STAT_OK)) begin
            n_err = ev_code;
            n_err_val = ev_val;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spc_pkg::ST_CLEAR;
            r_cnt <= '0;
            r_hi <= '0;
            r_err <= spc_pkg::STAT_OK;
            r_err_val <= 16'd0;
            r_gene_count <= spc_pkg::GENE_COUNT_RESET;
            r_chk_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            // Only entries below the count take part in the missing check.
            r_chk_valid <= scan_issue && (16'(r_cnt) < eff_n);
            r_out_valid <= (r_state == spc_pkg::ST_FLUSH);
            if (i_cfg_we) r_gene_count <= i_cfg_wdata;
            // Track the highest gene marked so the sweep clears it even if the count shrinks.
            if (r_state == spc_pkg::ST_FLUSH) begin
                r_hi <= '0;
            end else if ((r_state == spc_pkg::ST_LOOKUP) && ((CW'(r_addr) + CW'(1)) > r_hi)) begin
                r_hi <= CW'(r_addr) + CW'(1);
            end
            if (r_state == spc_pkg::ST_FLUSH) begin
                r_err <= spc_pkg::STAT_OK;
                r_err_val <= 16'd0;
            end else begin
                r_err <= n_err;
                r_err_val <= n_err_val;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_addr <= AW'(mag - 17'd1);
            r_last <= i_is_last;
        end
        r_chk_idx <= r_cnt[AW-1:0];
        if (r_state == spc_pkg::ST_FLUSH) begin
            r_out_status <= n_err;
            r_out_value <= (n_err == spc_pkg::STAT_OK) ? 16'd0 : n_err_val;
        end
    end

    // Seen-map memory with registered read; a read sees the value before a same-cycle write.
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        if (mem_re) r_rd_data <= mem[mem_raddr];
    end

    assign o_busy = (r_state != spc_pkg::ST_IDLE);
    assign o_valid = r_out_valid;
    assign o_status = r_out_status;
    assign o_bad_value = r_out_value;

endmodule

`default_nettype wire

@@ verif/spc_verdict_monitor.sv @@
// Monitor for the signed permutation checker: tracks gene words and checks each verdict word.
module spc_verdict_monitor #(
    parameter int MAX_GENES = 1024
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [spc_pkg::COUNT_W-1:0]        i_cfg_wdata,
    input  wire logic                               i_start,
    input  wire logic signed [spc_pkg::GENE_W-1:0]  i_gene_value,
    input  wire logic                               i_is_last,
    input  wire logic                               i_busy,
    input  wire logic                               i_valid,
    input  wire logic [2:0]                         i_status,
    input  wire logic signed [spc_pkg::GENE_W-1:0]  i_bad_value,
    output int                                      o_mismatches,
    output int                                      o_verdicts_pending
);

    typedef struct packed {
        spc_pkg::t_status                   status;
        logic signed [spc_pkg::GENE_W-1:0]  bad_value;
    } t_verdict;

    // Verdicts owed by the block, oldest first.
    t_verdict verdict_q[$];

    // Shadow of the block's list state and its count register.
    logic [MAX_GENES-1:0]              seen_mags;
    spc_pkg::t_status                  err_code;
    logic signed [spc_pkg::GENE_W-1:0] err_value;
    logic [spc_pkg::COUNT_W-1:0]       gene_count;
    int                                errors = 0;

    initial begin
        o_mismatches = 0;
        o_verdicts_pending = 0;
    end

    // Keep only the first error of a list.
    task automatic note_error(input spc_pkg::t_status code,
                              input logic signed [spc_pkg::GENE_W-1:0] value);
        if (err_code == spc_pkg::STAT_OK) begin
            err_code = code;
            err_value = value;
        end
    endtask

    // Apply one gene word; on a last word, queue the verdict and clear the list.
    task automatic predict_gene(input logic signed [spc_pkg::GENE_W-1:0] gene, input logic last);
        int          n;
        int          i;
        logic [16:0] mag;
        t_verdict    v;
        n = (gene_count > MAX_GENES) ? MAX_GENES : int'(gene_count);
        mag = gene[spc_pkg::GENE_W-1] ? (17'h10000 - {1'b0, gene}) : {1'b0, gene};
        if (mag == 0) begin
            note_error(spc_pkg::STAT_ZERO, gene);
        end else if (int'(mag) > n) begin
            note_error(spc_pkg::STAT_LARGE, gene);
        end else if (seen_mags[mag - 1]) begin
            note_error(spc_pkg::STAT_DUP, mag[spc_pkg::GENE_W-1:0]);
        end else begin
            seen_mags[mag - 1] = 1'b1;
        end
        if (last) begin
            // The missing scan only matters for an otherwise clean list.
            if (err_code == spc_pkg::STAT_OK) begin
                for (i = 0; i < n; i++) begin
                    if (!seen_mags[i]) begin
                        note_error(spc_pkg::STAT_MISSING, spc_pkg::GENE_W'(i + 1));
                        break;
                    end
                end
            end
            v.status = err_code;
            v.bad_value = (err_code == spc_pkg::STAT_OK) ? '0 : err_value;
            verdict_q.push_back(v);
            seen_mags = '0;
            err_code = spc_pkg::STAT_OK;
            err_value = '0;
        end
    endtask

    // Watch configuration, accepted gene words and verdict words on each edge.
    always @(posedge i_clk) begin : watch
        t_verdict want;
        if (!i_rst_n) begin
            seen_mags = '0;
            err_code = spc_pkg::STAT_OK;
            err_value = '0;
            gene_count = spc_pkg::GENE_COUNT_RESET;
            verdict_q.delete();
        end else begin
            if (i_cfg_we) begin
                gene_count = i_cfg_wdata;
            end
            if (i_start && !i_busy) begin
                predict_gene(i_gene_value, i_is_last);
            end
            if (i_valid !== 1'b0) begin
                if (verdict_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected verdict word, expected none, actual status %0d value %0d",
                             $time, i_status, $signed(i_bad_value));
                end else begin
                    want = verdict_q.pop_front();
                    if (i_status !== want.status) begin
                        errors++;
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, want.status, i_status);
                    end
                    if (i_bad_value !== want.bad_value) begin
                        errors++;
                        $display("%0t: bad_value mismatch, expected %0d, actual %0d",
                                 $time, $signed(want.bad_value), $signed(i_bad_value));
                    end
                end
            end
        end
        o_mismatches <= errors;
        o_verdicts_pending <= verdict_q.size();
    end

endmodule

@@ verif/tb_signed_permutation_checker_core.sv @@
// Testbench top for the signed permutation checker: drives gene lists and gives the verdict.
module tb_signed_permutation_checker_core;

    localparam int MAX_GENES   = 1024;
    localparam int GENE_BUDGET = 1540;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_cfg_we;
    logic [spc_pkg::COUNT_W-1:0]       i_cfg_wdata;
    logic                              i_start;
    logic signed [spc_pkg::GENE_W-1:0] i_gene_value;
    logic                              i_is_last;
    logic                              o_busy;
    logic                              o_valid;
    logic [2:0]                        o_status;
    logic signed [spc_pkg::GENE_W-1:0] o_bad_value;

    int mismatches;
    int verdicts_pending;

    // Genes of the list being built, as plain integers.
    int list_q[$];
    int genes_sent;
    int lists_sent;
    int count_writes;
    int cur_count;

    signed_permutation_checker_core #(
        .MAX_GENES(MAX_GENES)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_start      (i_start),
        .i_gene_value (i_gene_value),
        .i_is_last    (i_is_last),
        .o_busy       (o_busy),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_bad_value  (o_bad_value)
    );

    spc_verdict_monitor #(
        .MAX_GENES(MAX_GENES)
    ) verdict_monitor (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_start            (i_start),
        .i_gene_value       (i_gene_value),
        .i_is_last          (i_is_last),
        .i_busy             (o_busy),
        .i_valid            (o_valid),
        .i_status           (o_status),
        .i_bad_value        (o_bad_value),
        .o_mismatches       (mismatches),
        .o_verdicts_pending (verdicts_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog against a hung block.
    initial begin
        #20000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Send one gene word, sometimes after a random gap, and wait until it is taken.
    task automatic drive_gene(input int gene, input logic last);
        bit gaps_on;
        gaps_on = !(genes_sent >= 700 && genes_sent < 1000);
        if (gaps_on && $urandom_range(0, 99) < 18) begin
            i_start <= 1'b0;
            i_gene_value <= spc_pkg::GENE_W'($urandom);
            i_is_last <= 1'($urandom);
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_gene_value <= spc_pkg::GENE_W'(gene);
        i_is_last <= last;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        genes_sent++;
    endtask

    task automatic run_list();
        int i;
        for (i = 0; i < list_q.size(); i++) begin
            drive_gene(list_q[i], i == list_q.size() - 1);
        end
        lists_sent++;
    endtask

    // Let every owed verdict arrive and the block fall idle.
    task automatic wait_idle();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (verdicts_pending != 0 || o_busy !== 1'b0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic program_count(input int value);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= spc_pkg::COUNT_W'(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_count = value;
        count_writes++;
    endtask

    // Build a list: mostly shuffled signed permutations, some broken, some loose noise.
    task automatic build_random_list();
        int n;
        int r;
        int j;
        int pos;
        int tmp;
        n = (cur_count > MAX_GENES) ? MAX_GENES : cur_count;
        r = $urandom_range(0, 99);
        list_q.delete();
        if (n == 0 || n > 64 || r >= 89) begin
            for (j = 0; j < $urandom_range(1, 8); j++) begin
                if ($urandom_range(0, 2) == 0) begin
                    tmp = int'($urandom_range(0, 65535)) - 32768;
                end else begin
                    tmp = $urandom_range(0, n + 1);
                    if ($urandom_range(0, 1) == 1) tmp = -tmp;
                end
                list_q.push_back(tmp);
            end
        end else begin
            for (j = 1; j <= n; j++) begin
                list_q.push_back(($urandom_range(0, 1) == 1) ? -j : j);
            end
            for (j = n - 1; j > 0; j--) begin
                pos = $urandom_range(0, j);
                tmp = list_q[pos];
                list_q[pos] = list_q[j];
                list_q[j] = tmp;
            end
            if (r >= 55 && r < 67) begin
                // Short list: one gene dropped, or a lone gene replaced by one out of range.
                if (list_q.size() > 1) begin
                    list_q.delete($urandom_range(0, list_q.size() - 1));
                end else begin
                    list_q[0] = n + 1;
                end
            end else if (r >= 67 && r < 79) begin
                // Repeat an existing gene, either inserted or overwriting another.
                tmp = list_q[$urandom_range(0, list_q.size() - 1)];
                if ($urandom_range(0, 1) == 1) tmp = -tmp;
                pos = $urandom_range(0, list_q.size() - 1);
                if ($urandom_range(0, 1) == 1) begin
                    list_q[pos] = tmp;
                end else begin
                    list_q.insert(pos, tmp);
                end
            end else if (r >= 79) begin
                // A zero or out-of-range gene somewhere in the list.
                case ($urandom_range(0, 3))
                    0: tmp = 0;
                    1: tmp = $urandom_range(n + 1, 32767);
                    2: tmp = -32768;
                    default: tmp = -int'($urandom_range(n + 1, 32767));
                endcase
                list_q.insert($urandom_range(0, list_q.size()), tmp);
            end
        end
    endtask

    initial begin
        int r;
        int value;
        int lists;
        int k;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_wdata <= '0;
        i_start <= 1'b0;
        i_gene_value <= '0;
        i_is_last <= 1'b0;
        genes_sent = 0;
        lists_sent = 0;
        count_writes = 0;
        cur_count = spc_pkg::GENE_COUNT_RESET;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed lists at the reset count: zero, extremes, missing, duplicates.
        list_q = '{0};                 run_list();
        list_q = '{-32768};            run_list();
        list_q = '{32767};             run_list();
        list_q = '{1024, -3};          run_list();
        list_q = '{2, -2, 0};          run_list();
        list_q = '{0, 5000, 1, 1};     run_list();

        // Smallest count.
        program_count(1);
        list_q = '{-1};                run_list();
        list_q = '{2};                 run_list();
        list_q = '{1, 1};              run_list();

        // Count of zero: every nonzero gene too large, nothing missing.
        program_count(0);
        list_q = '{1};                 run_list();
        list_q = '{-5, 0};             run_list();

        // Count beyond the map size is clipped.
        program_count(2047);
        list_q = '{-1025};             run_list();

        // A clean signed permutation.
        program_count(4);
        list_q = '{3, -1, 4, -2};      run_list();

        // Random phases, each with its own count.
        while (genes_sent < GENE_BUDGET) begin
            r = $urandom_range(0, 99);
            if (r < 12) begin
                case ($urandom_range(0, 5))
                    0: value = 0;
                    1: value = 1;
                    2: value = 1024;
                    3: value = 1025;
                    4: value = 2047;
                    default: value = $urandom_range(65, 1023);
                endcase
            end else if (r < 25) begin
                value = $urandom_range(25, 48);
            end else begin
                value = $urandom_range(1, 24);
            end
            program_count(value);
            lists = (value > 64) ? $urandom_range(1, 3) : $urandom_range(3, 8);
            for (k = 0; k < lists && genes_sent < GENE_BUDGET; k++) begin
                build_random_list();
                run_list();
            end
        end

        wait_idle();
        repeat (1100) @(posedge i_clk);

        $display("Sent %0d genes in %0d lists under %0d gene_count writes.",
                 genes_sent, lists_sent, count_writes);
        $display("Counts spanned 0 to 2047; lists were clean, short, repeated and noisy.");
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hdl/spc_pkg.sv
hdl/signed_permutation_checker_core.sv
verif/spc_verdict_monitor.sv
verif/tb_signed_permutation_checker_core.sv
